>>> sv/tfw_pkg.sv
// ----------------------------------------------------------------------------
// tfw_pkg
// Shared types, codes and helper functions for the fragmenting TLV8 writer.
// ----------------------------------------------------------------------------
package tfw_pkg;

   // Buffer geometry
   localparam int BUFFER_BYTES  = 4096;
   localparam int FRAGMENT_MAX  = 255;
   localparam int MAX_RESULTS   = 3;

   // Result queue geometry
   localparam int QUEUE_DEPTH   = 8;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int KIND_W   = 2;
   localparam int TYPE_W   = 8;
   localparam int LEN_W    = 12;
   localparam int BYTE_W   = 8;
   localparam int OFFS_W   = 12;
   localparam int STAT_W   = 2;
   localparam int USED_W   = 13;
   localparam int CAP_W    = 13;
   localparam int NEED_W   = 14;
   localparam int FRAGS_W  = 5;
   localparam int NRES_W   = 2;

   // Input kinds
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_VALUE = 2'd2;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STAT_W-1:0] ST_REPEAT   = 2'd2;
   localparam logic [STAT_W-1:0] ST_UNEXPECT = 2'd3;

   localparam logic [CAP_W-1:0]  CAP_LIMIT = CAP_W'(BUFFER_BYTES);
   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(BUFFER_BYTES);

   // One result item
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_valid;
      logic [OFFS_W-1:0] out_offset;
      logic [STAT_W-1:0] status;
      logic [USED_W-1:0] used_bytes;
      logic              last;
   } rec_type;

   // Up to three results pushed into the queue in one cycle
   typedef struct packed {
      logic [NRES_W-1:0]           count;
      rec_type [MAX_RESULTS-1:0]   recs;
   } push_type;

   // Fragment length: smaller of the remaining value and one full fragment
   function automatic logic [TYPE_W-1:0] frag_len(input logic [LEN_W-1:0] remaining);
      logic [TYPE_W-1:0] res;
      if (remaining > LEN_W'(FRAGMENT_MAX)) begin
         res = TYPE_W'(FRAGMENT_MAX);
      end else begin
         res = remaining[TYPE_W-1:0];
      end
      return res;
   endfunction

   // Number of fragments, at least one; ceil(len / 255) by the
   // (x + (x >> 8) + 1) >> 8 reciprocal form, exact for every 12-bit len
   function automatic logic [FRAGS_W-1:0] frag_count(input logic [LEN_W-1:0] len);
      logic [15:0] x;
      logic [15:0] q;
      logic [FRAGS_W-1:0] res;
      x = 16'(len) + 16'(FRAGMENT_MAX - 1);
      q = (x + (x >> 8) + 16'd1) >> 8;
      if (len == '0) begin
         res = FRAGS_W'(1);
      end else begin
         res = q[FRAGS_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> sv/tfw_encoder.sv
// ----------------------------------------------------------------------------
// tfw_encoder
// Input register, element state and the single-pass encode logic that turns
// one input transaction into one to three result records.
// ----------------------------------------------------------------------------
module tfw_encoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tfw_pkg::KIND_W-1:0]  req_kind,
   input  logic [tfw_pkg::TYPE_W-1:0]  req_tlv_type,
   input  logic [tfw_pkg::LEN_W-1:0]   req_value_length,
   input  logic [tfw_pkg::BYTE_W-1:0]  req_value_byte,
   input  logic                        csr_wr_en,
   input  logic [tfw_pkg::CAP_W-1:0]   csr_wr_data,
   input  logic                        room,
   output tfw_pkg::push_type           push
);
   import tfw_pkg::*;

   // Input register
   logic              s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0] s1_kind_ff;
   logic [TYPE_W-1:0] s1_type_ff;
   logic [LEN_W-1:0]  s1_len_ff;
   logic [BYTE_W-1:0] s1_byte_ff;

   // Capacity register
   logic [CAP_W-1:0]  cap_ff;

   // Element state
   logic [USED_W-1:0] used_ff, used_in;
   logic [TYPE_W-1:0] prev_type_ff, prev_type_in;
   logic              open_ff, open_in;
   logic [TYPE_W-1:0] cur_type_ff, cur_type_in;
   logic [LEN_W-1:0]  val_rem_ff, val_rem_in;
   logic [TYPE_W-1:0] frag_rem_ff, frag_rem_in;

   logic              fire;
   logic [CAP_W-1:0]  cap_eff;
   logic [NEED_W-1:0] need;
   logic [USED_W-1:0] used_p1, used_p2, used_p3;
   logic [LEN_W-1:0]  val_dec;
   logic [TYPE_W-1:0] frag_dec;
   logic [NRES_W-1:0] n_res;
   rec_type [MAX_RESULTS-1:0] recs;

   // Stall while a held item cannot move into the queue
   assign fire      = s1_valid_ff && room;
   assign req_stall = s1_valid_ff && !room;

   always_comb begin
      if (req_stall) begin
         s1_valid_in = s1_valid_ff;
      end else begin
         s1_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_kind_ff <= req_kind;
         s1_type_ff <= req_tlv_type;
         s1_len_ff  <= req_value_length;
         s1_byte_ff <= req_value_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // Space check terms
   assign cap_eff  = (cap_ff < CAP_LIMIT) ? cap_ff : CAP_LIMIT;
   assign need     = NEED_W'(used_ff) + NEED_W'(s1_len_ff)
                   + NEED_W'({frag_count(s1_len_ff), 1'b0});
   assign used_p1  = used_ff + USED_W'(1);
   assign used_p2  = used_ff + USED_W'(2);
   assign used_p3  = used_ff + USED_W'(3);
   assign val_dec  = val_rem_ff - LEN_W'(1);
   assign frag_dec = frag_rem_ff - TYPE_W'(1);

   // Encode one item
   always_comb begin
      used_in      = used_ff;
      prev_type_in = prev_type_ff;
      open_in      = open_ff;
      cur_type_in  = cur_type_ff;
      val_rem_in   = val_rem_ff;
      frag_rem_in  = frag_rem_ff;
      n_res        = NRES_W'(1);
      recs         = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         recs[i].used_bytes = used_ff;
      end

      unique case (s1_kind_ff)
         KIND_CLEAR: begin
            used_in      = '0;
            prev_type_in = '0;
            open_in      = 1'b0;
            cur_type_in  = '0;
            val_rem_in   = '0;
            frag_rem_in  = '0;
            recs[0].status     = ST_OK;
            recs[0].used_bytes = '0;
         end
         KIND_START: begin
            priority if (open_ff) begin
               recs[0].status = ST_UNEXPECT;
            end else if (used_ff != '0 && s1_type_ff == prev_type_ff) begin
               recs[0].status = ST_REPEAT;
            end else if (need > NEED_W'(cap_eff)) begin
               recs[0].status = ST_NO_SPACE;
            end else begin
               // first fragment header: type byte, then length byte
               cur_type_in  = s1_type_ff;
               prev_type_in = s1_type_ff;
               val_rem_in   = s1_len_ff;
               frag_rem_in  = frag_len(s1_len_ff);
               open_in      = (s1_len_ff != '0);
               used_in      = used_p2;
               n_res        = NRES_W'(2);
               recs[0].out_byte   = s1_type_ff;
               recs[0].out_valid  = 1'b1;
               recs[0].out_offset = used_ff[OFFS_W-1:0];
               recs[0].used_bytes = used_p1;
               recs[1].out_byte   = frag_len(s1_len_ff);
               recs[1].out_valid  = 1'b1;
               recs[1].out_offset = used_p1[OFFS_W-1:0];
               recs[1].used_bytes = used_p2;
            end
         end
         KIND_VALUE: begin
            if (open_ff) begin
               recs[0].out_byte   = s1_byte_ff;
               recs[0].out_valid  = 1'b1;
               recs[0].out_offset = used_ff[OFFS_W-1:0];
               recs[0].used_bytes = used_p1;
               used_in    = used_p1;
               val_rem_in = val_dec;
               priority if (val_dec == '0) begin
                  open_in     = 1'b0;
                  frag_rem_in = '0;
               end else if (frag_dec == '0) begin
                  // fragment full: header of the next fragment
                  frag_rem_in = frag_len(val_dec);
                  used_in     = used_p3;
                  n_res       = NRES_W'(3);
                  recs[1].out_byte   = cur_type_ff;
                  recs[1].out_valid  = 1'b1;
                  recs[1].out_offset = used_p1[OFFS_W-1:0];
                  recs[1].used_bytes = used_p2;
                  recs[2].out_byte   = frag_len(val_dec);
                  recs[2].out_valid  = 1'b1;
                  recs[2].out_offset = used_p2[OFFS_W-1:0];
                  recs[2].used_bytes = used_p3;
               end else begin
                  frag_rem_in = frag_dec;
               end
            end else begin
               recs[0].status = ST_UNEXPECT;
            end
         end
         default: begin
            recs[0].status = ST_UNEXPECT;
         end
      endcase

      // mark the final record of this item
      for (int i = 0; i < MAX_RESULTS; i++) begin
         recs[i].last = (NRES_W'(i + 1) == n_res);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         prev_type_ff <= '0;
         open_ff      <= 1'b0;
         cur_type_ff  <= '0;
         val_rem_ff   <= '0;
         frag_rem_ff  <= '0;
      end else if (fire) begin
         used_ff      <= used_in;
         prev_type_ff <= prev_type_in;
         open_ff      <= open_in;
         cur_type_ff  <= cur_type_in;
         val_rem_ff   <= val_rem_in;
         frag_rem_ff  <= frag_rem_in;
      end
   end

   assign push.count = fire ? n_res : '0;
   assign push.recs  = recs;

endmodule

>>> sv/tfw_result_queue.sv
// ----------------------------------------------------------------------------
// tfw_result_queue
// Result FIFO: up to three records in a cycle, one out per unstalled cycle.
// ----------------------------------------------------------------------------
module tfw_result_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  tfw_pkg::push_type            push,
   output logic                         room,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tfw_pkg::rec_type             head_rec
);
   import tfw_pkg::*;

   rec_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;

   // Room for a full three-record push
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head_rec  = entry_ff[head_ff];

   assign head_in  = pop ? head_ff + QPTR_W'(1) : head_ff;
   assign tail_in  = tail_ff + QPTR_W'(push.count);
   assign count_in = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Record storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (NRES_W'(i) < push.count) begin
            entry_ff[tail_ff + QPTR_W'(i)] <= push.recs[i];
         end
      end
   end

endmodule

>>> sv/tlv8_fragmenting_writer_top.sv
// ----------------------------------------------------------------------------
// tlv8_fragmenting_writer_top
// Serializes TLV8 elements into a buffer of configured capacity, splitting
// values longer than 255 bytes into fragments with their own headers, and
// reports every written byte with its buffer offset.
// ----------------------------------------------------------------------------
// An input transaction is taken every cycle unless stalled, into an input
// register and encoded there in one pass; it yields one result (clear, value
// byte, rejected or unexpected item), two (accepted start: type and length
// bytes) or three (value byte that closes a full fragment, plus the next
// fragment header). Results leave through an eight-record queue at one per
// cycle unless the receiver stalls; the sustained input rate is one item per
// cycle while items average one result and the receiver does not stall; the
// output port's one record per cycle sets the rate otherwise. An element's
// space and type are checked at its start, so it is written whole or not at
// all unless a clear abandons it; capacity writes apply to later starts.
// ----------------------------------------------------------------------------
module tlv8_fragmenting_writer_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tfw_pkg::KIND_W-1:0]  req_kind,
   input  logic [tfw_pkg::TYPE_W-1:0]  req_tlv_type,
   input  logic [tfw_pkg::LEN_W-1:0]   req_value_length,
   input  logic [tfw_pkg::BYTE_W-1:0]  req_value_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tfw_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_out_valid,
   output logic [tfw_pkg::OFFS_W-1:0]  rsp_out_offset,
   output logic [tfw_pkg::STAT_W-1:0]  rsp_status,
   output logic [tfw_pkg::USED_W-1:0]  rsp_used_bytes,
   output logic                        rsp_last,
   input  logic                        csr_wr_en,
   input  logic [tfw_pkg::CAP_W-1:0]   csr_wr_data
);
   import tfw_pkg::*;

   push_type push;
   rec_type  head_rec;
   logic     room;

   // Encoder
   tfw_encoder u_encoder (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_tlv_type     (req_tlv_type),
      .req_value_length (req_value_length),
      .req_value_byte   (req_value_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .room             (room),
      .push             (push)
   );

   // Result queue
   tfw_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head_rec  (head_rec)
   );

   assign rsp_out_byte   = head_rec.out_byte;
   assign rsp_out_valid  = head_rec.out_valid;
   assign rsp_out_offset = head_rec.out_offset;
   assign rsp_status     = head_rec.status;
   assign rsp_used_bytes = head_rec.used_bytes;
   assign rsp_last       = head_rec.last;

`ifndef NO_ASSERTIONS
   // Records are pushed only when the queue has room for a full item
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != '0) |-> room)
      else $error("push without queue room");

   // A written byte always carries status ok
   a_written_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_valid) |-> (rsp_status == ST_OK))
      else $error("written byte with error status");

   // The used count right after a written byte is its offset plus one
   a_used_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_valid) |->
         (rsp_used_bytes[OFFS_W-1:0] == rsp_out_offset + OFFS_W'(1)))
      else $error("used count does not follow offset");

   // A non-written result carries no byte and no offset
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_valid) |-> (rsp_out_byte == '0 && rsp_out_offset == '0))
      else $error("non-written result carries data");
`endif

endmodule

>>> sim/tlv8_fragmenting_writer_top_test.sv
// ----------------------------------------------------------------------------
// tlv8_fragmenting_writer_top_test
// Self-checking bench for the fragmenting TLV8 writer. A short table of
// directed transactions is followed by random element sequences under several
// buffer capacities. Sender bursts and receiver stalls are random. Every
// result is compared field by field with the output of a behavioral encoder.
// ----------------------------------------------------------------------------
module tlv8_fragmenting_writer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tfw_pkg::*;

   // Input kind with no meaning; the block answers it as an unexpected item
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_SLACK  = 8;
   localparam int PHASE_ITEMS  = 58;
   localparam int NUM_PHASES   = 7;
   localparam int MAX_REPORTS  = 10;

   // One directed transaction; chk marks rows with hand-typed results
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TYPE_W-1:0] ttype;
      logic [LEN_W-1:0]  vlen;
      logic [BYTE_W-1:0] vbyte;
      logic              chk;
      logic [STAT_W-1:0] st;
      logic [USED_W-1:0] used;
   } stim_row_type;

   localparam int NUM_DIRECTED = 20;
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      // value byte and unused kind with nothing open
      '{KIND_VALUE,  8'h00, 12'd0,    8'hFF, 1'b1, ST_UNEXPECT, 13'd0},
      '{KIND_UNUSED, 8'hFF, 12'd4094, 8'hFF, 1'b1, ST_UNEXPECT, 13'd0},
      // zero-length element, then same type again
      '{KIND_START,  8'h00, 12'd0,    8'h00, 1'b1, ST_OK,       13'd2},
      '{KIND_START,  8'h00, 12'd1,    8'h00, 1'b1, ST_REPEAT,   13'd2},
      // two-byte element with a start arriving in the middle
      '{KIND_START,  8'hFF, 12'd2,    8'h00, 1'b1, ST_OK,       13'd4},
      '{KIND_START,  8'h11, 12'd3,    8'h00, 1'b1, ST_UNEXPECT, 13'd4},
      '{KIND_VALUE,  8'h00, 12'd0,    8'h00, 1'b1, ST_OK,       13'd5},
      '{KIND_VALUE,  8'h00, 12'd0,    8'hFF, 1'b1, ST_OK,       13'd6},
      '{KIND_START,  8'hFF, 12'd1,    8'h00, 1'b1, ST_REPEAT,   13'd6},
      '{KIND_START,  8'h5A, 12'd4094, 8'h00, 1'b1, ST_NO_SPACE, 13'd6},
      // after a clear, type zero is no longer a repeat
      '{KIND_CLEAR,  8'h00, 12'd0,    8'h00, 1'b1, ST_OK,       13'd0},
      '{KIND_START,  8'h00, 12'd0,    8'h00, 1'b1, ST_OK,       13'd2},
      '{KIND_CLEAR,  8'hFF, 12'd4095, 8'hFF, 1'b1, ST_OK,       13'd0},
      // one byte over capacity, then exactly at capacity
      '{KIND_START,  8'h80, 12'd4065, 8'h00, 1'b1, ST_NO_SPACE, 13'd0},
      '{KIND_START,  8'h80, 12'd4064, 8'h00, 1'b1, ST_OK,       13'd2},
      // clear abandons the open element
      '{KIND_CLEAR,  8'h00, 12'd0,    8'h00, 1'b1, ST_OK,       13'd0},
      '{KIND_START,  8'h3C, 12'd5,    8'h00, 1'b0, ST_OK,       13'd0},
      '{KIND_VALUE,  8'h00, 12'd0,    8'h12, 1'b0, ST_OK,       13'd0},
      '{KIND_START,  8'h3C, 12'd1,    8'h00, 1'b1, ST_UNEXPECT, 13'd3},
      '{KIND_CLEAR,  8'h00, 12'd0,    8'h00, 1'b1, ST_OK,       13'd0}
   };

   localparam int NUM_CAP_SETTINGS = 6;
   localparam logic [CAP_W-1:0] CAP_SETTINGS [NUM_CAP_SETTINGS] = '{
      13'd8191, 13'd0, 13'd2, 13'd300, 13'd41, 13'd4096
   };

   // DUT signals
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [TYPE_W-1:0]   req_tlv_type = '0;
   logic [LEN_W-1:0]    req_value_length = '0;
   logic [BYTE_W-1:0]   req_value_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_out_valid;
   logic [OFFS_W-1:0]   rsp_out_offset;
   logic [STAT_W-1:0]   rsp_status;
   logic [USED_W-1:0]   rsp_used_bytes;
   logic                rsp_last;
   logic                csr_wr_en = 1'b0;
   logic [CAP_W-1:0]    csr_wr_data = '0;

   // Encoder image: configuration and element state
   logic [CAP_W-1:0]    enc_capacity = CAP_RESET;
   int                  enc_used = 0;
   logic [TYPE_W-1:0]   enc_prev_type = '0;
   logic                enc_open = 1'b0;
   logic [TYPE_W-1:0]   enc_cur_type = '0;
   int                  enc_value_left = 0;
   int                  enc_frag_left = 0;

   // Buffer writes and status records still owed by the block
   rec_type             tlv_results_q [$];

   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  burst_left = 0;
   int                  stall_run = 0;
   int                  stall_mode = 0;

   tlv8_fragmenting_writer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_tlv_type     (req_tlv_type),
      .req_value_length (req_value_length),
      .req_value_byte   (req_value_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_offset   (rsp_out_offset),
      .rsp_status       (rsp_status),
      .rsp_used_bytes   (rsp_used_bytes),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Queue one result record; byte and offset read zero when nothing is written
   function automatic void push_result(input logic [BYTE_W-1:0] wbyte, input logic wvalid,
                                       input int woffset, input logic [STAT_W-1:0] st);
      rec_type rec;
      rec.out_byte   = wvalid ? wbyte : '0;
      rec.out_valid  = wvalid;
      rec.out_offset = wvalid ? OFFS_W'(woffset) : '0;
      rec.status     = st;
      rec.used_bytes = USED_W'(enc_used);
      rec.last       = 1'b0;
      tlv_results_q.push_back(rec);
   endfunction

   // Type and length bytes of the next fragment
   function automatic void emit_frag_header();
      int flen;
      flen = (enc_value_left > FRAGMENT_MAX) ? FRAGMENT_MAX : enc_value_left;
      enc_used++;
      push_result(enc_cur_type, 1'b1, enc_used - 1, ST_OK);
      enc_used++;
      push_result(BYTE_W'(flen), 1'b1, enc_used - 1, ST_OK);
      enc_frag_left = flen;
   endfunction

   // Encode one accepted transaction and queue the records it causes
   function automatic void tlv_encode_step(input logic [KIND_W-1:0] kind,
                                           input logic [TYPE_W-1:0] ttype,
                                           input logic [LEN_W-1:0] vlen,
                                           input logic [BYTE_W-1:0] vbyte);
      int cap_eff;
      int frags;
      int need;
      cap_eff = (int'(enc_capacity) < BUFFER_BYTES) ? int'(enc_capacity) : BUFFER_BYTES;
      frags   = (vlen == '0) ? 1 : (int'(vlen) + FRAGMENT_MAX - 1) / FRAGMENT_MAX;
      need    = enc_used + int'(vlen) + 2 * frags;
      case (kind)
         KIND_CLEAR: begin
            enc_used       = 0;
            enc_prev_type  = '0;
            enc_open       = 1'b0;
            enc_cur_type   = '0;
            enc_value_left = 0;
            enc_frag_left  = 0;
            push_result('0, 1'b0, 0, ST_OK);
         end
         KIND_START: begin
            if (enc_open) begin
               push_result('0, 1'b0, 0, ST_UNEXPECT);
            end else if (enc_used != 0 && ttype == enc_prev_type) begin
               push_result('0, 1'b0, 0, ST_REPEAT);
            end else if (need > cap_eff) begin
               push_result('0, 1'b0, 0, ST_NO_SPACE);
            end else begin
               enc_cur_type   = ttype;
               enc_prev_type  = ttype;
               enc_value_left = int'(vlen);
               emit_frag_header();
               enc_open = (vlen != '0);
            end
         end
         KIND_VALUE: begin
            if (enc_open) begin
               enc_used++;
               push_result(vbyte, 1'b1, enc_used - 1, ST_OK);
               enc_value_left--;
               enc_frag_left--;
               if (enc_value_left == 0) begin
                  enc_open      = 1'b0;
                  enc_frag_left = 0;
               end else if (enc_frag_left == 0) begin
                  emit_frag_header();
               end
            end else begin
               push_result('0, 1'b0, 0, ST_UNEXPECT);
            end
         end
         default: begin
            push_result('0, 1'b0, 0, ST_UNEXPECT);
         end
      endcase
      tlv_results_q[tlv_results_q.size() - 1].last = 1'b1;
   endfunction

   // Present one transaction, wait for acceptance, then maybe pause the sender
   task automatic send_tlv_item(input logic [KIND_W-1:0] kind, input logic [TYPE_W-1:0] ttype,
                                input logic [LEN_W-1:0] vlen, input logic [BYTE_W-1:0] vbyte,
                                input logic chk, input logic [STAT_W-1:0] chk_st,
                                input logic [USED_W-1:0] chk_used);
      int first;
      req_kind         <= kind;
      req_tlv_type     <= ttype;
      req_value_length <= vlen;
      req_value_byte   <= vbyte;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      first = tlv_results_q.size();
      tlv_encode_step(kind, ttype, vlen, vbyte);
      // hand-typed rows: first status and final fill level
      if (chk) begin
         tlv_results_q[first].status = chk_st;
         tlv_results_q[tlv_results_q.size() - 1].used_bytes = chk_used;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Mostly well-formed element sequences, with some noise
   task automatic send_random_item();
      int r;
      int room;
      int n;
      int cap_eff;
      logic [KIND_W-1:0] k;
      logic [TYPE_W-1:0] t;
      logic [LEN_W-1:0]  l;
      logic [BYTE_W-1:0] b;
      r = $urandom_range(0, 99);
      t = TYPE_W'($urandom_range(0, 255));
      l = LEN_W'($urandom_range(0, 4095));
      b = BYTE_W'($urandom_range(0, 255));
      if (enc_open) begin
         if (r < 95) k = KIND_VALUE;
         else if (r < 97) k = KIND_START;
         else if (r < 99) k = KIND_UNUSED;
         else k = KIND_CLEAR;
      end else if (r < 8) begin
         k = KIND_VALUE;
      end else if (r < 14) begin
         k = KIND_CLEAR;
      end else if (r < 18) begin
         k = KIND_UNUSED;
      end else begin
         k = KIND_START;
         if (r < 28) t = enc_prev_type;
         cap_eff = (int'(enc_capacity) < BUFFER_BYTES) ? int'(enc_capacity) : BUFFER_BYTES;
         room = cap_eff - enc_used;
         r = $urandom_range(0, 99);
         if (r < 60) begin
            l = LEN_W'($urandom_range(0, 6));
         end else if (r < 75) begin
            l = LEN_W'($urandom_range(7, 40));
         end else if (r < 83) begin
            l = LEN_W'($urandom_range(254, 258));
         end else if (r < 95 && room <= 300) begin
            // largest length that still fits, or one more
            n = (room > 2) ? room - 2 : 0;
            while (n > 0 && n + 2 * ((n + FRAGMENT_MAX - 1) / FRAGMENT_MAX) > room) n--;
            l = LEN_W'(n + $urandom_range(0, 1));
         end else if (r < 95) begin
            l = LEN_W'($urandom_range(0, 6));
         end else begin
            l = LEN_W'($urandom_range(4065, 4095));
         end
      end
      send_tlv_item(k, t, l, b, 1'b0, ST_OK, '0);
   endtask

   // Hold the sender and wait until every owed record has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      while (tlv_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      enc_capacity  = cap;
   endtask

   // Stimulus
   initial begin
      logic [CAP_W-1:0] cap;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_tlv_item(DIRECTED[i].kind, DIRECTED[i].ttype, DIRECTED[i].vlen,
                       DIRECTED[i].vbyte, DIRECTED[i].chk, DIRECTED[i].st, DIRECTED[i].used);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // leave an element open across the capacity change
         if (!enc_open) begin
            send_tlv_item(KIND_START, enc_prev_type + 8'd1, LEN_W'($urandom_range(5, 40)),
                          '0, 1'b0, ST_OK, '0);
         end
         drain_results();
         cap = (p < NUM_CAP_SETTINGS) ? CAP_SETTINGS[p] : CAP_W'($urandom_range(0, 8191));
         write_capacity(cap);
         for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
      end

      drain_results();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Receiver stall: modes of no stall, random stall and long stall runs
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_run  <= $urandom_range(32, 200);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 35);
         default: rsp_stall <= ((stall_run % 16) < 11);
      endcase
   end

   // Result checking against the oldest owed record
   always @(posedge clock) begin
      rec_type got;
      rec_type want;
      got = '{rsp_out_byte, rsp_out_valid, rsp_out_offset, rsp_status, rsp_used_bytes,
              rsp_last};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tlv_results_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("unexpected result: byte=%02h valid=%0d off=%0d st=%0d used=%0d last=%0d",
                        got.out_byte, got.out_valid, got.out_offset, got.status,
                        got.used_bytes, got.last);
            end
         end else begin
            want = tlv_results_q.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("mismatch exp: byte=%02h valid=%0d off=%0d st=%0d used=%0d last=%0d",
                           want.out_byte, want.out_valid, want.out_offset, want.status,
                           want.used_bytes, want.last);
                  $display("         got: byte=%02h valid=%0d off=%0d st=%0d used=%0d last=%0d",
                           got.out_byte, got.out_valid, got.out_offset, got.status,
                           got.used_bytes, got.last);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
